@@ rtl/mrk_pkg.sv @@
// Package for the Merkle root block: payload types, SHA-256 constants, the
// domain string and the compression handshake. Used by every module in rtl/.
`timescale 1ns / 1ps
package mrk_pkg;

    typedef struct packed {
        logic        word_valid;
        logic [63:0] leaf_word;
        logic        close_table;
    } t_in_item;

    typedef struct packed {
        logic [63:0] root_word;
        logic [1:0]  error_code;
        logic        last_word;
    } t_out_item;

    localparam logic [1:0] ERR_OK      = 2'd0;
    localparam logic [1:0] ERR_EMPTY   = 2'd1;
    localparam logic [1:0] ERR_TOOMANY = 2'd2;
    localparam logic [1:0] ERR_PARTIAL = 2'd3;

    // Domain string, 30 ASCII bytes, most significant byte first.
    localparam logic [239:0] DOMAIN_TEXT =
        240'h64656c74_61726564_7563652e_3030342e_6d65726b_6c652d6e_6f64652e_7631;

    localparam logic [255:0] INITIAL_H = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        case (t)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Handshake between the tree sequencer and the compression core.
    typedef struct packed {
        logic         start;
        logic         second;   // 1: chain from the previous block's state
        logic [511:0] block;
    } t_cmp_req;

    typedef struct packed {
        logic         done;
        logic [255:0] digest;
    } t_cmp_rsp;

endpackage

@@ rtl/merkle_root_sha256.sv @@
// Merkle root over SHA-256: leaf table in a node memory, tree sequencer,
// result register. Depends on mrk_pkg and mrk_compress.
//
//  channel | direction | payload type        | handshake
//  in      | input     | mrk_pkg::t_in_item  | i_in_valid / o_in_ready
//  out     | output    | mrk_pkg::t_out_item | o_out_valid / i_out_ready
//
// A leaf word, or an item with no close, leaves the block ready for the next item.
// A close walks the tree level by level; a level of n nodes gives (n+1)/2
// parents, each made by reading two child digests as eight words, running two
// compressions and writing four words. The root is then read back, and four root
// words leave, one per cycle while ready. An error close offers its item in
// the next cycle. Reset is synchronous; the node memory needs none.
// Input is not taken while a close is being worked or results are pending.
`timescale 1ns / 1ps
module merkle_root_sha256 #(
    parameter int MAX_LEAVES = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mrk_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mrk_pkg::t_out_item  o_out_data
);
    localparam int WORDS = MAX_LEAVES * 4;
    localparam int AW    = $clog2(WORDS);
    localparam int CW    = $clog2(WORDS + 1);
    localparam int NW    = $clog2(MAX_LEAVES + 1);

    typedef enum logic [7:0] {
        S_LOAD  = 8'b00000001,
        S_READ  = 8'b00000010,
        S_CMP1  = 8'b00000100,
        S_CMP2  = 8'b00001000,
        S_WRITE = 8'b00010000,
        S_ROOT  = 8'b00100000,
        S_OUT   = 8'b01000000,
        S_ERR   = 8'b10000000
    } t_state;

    t_state      r_state;
    logic [CW-1:0] r_word_count;
    logic        r_overflow;
    logic [NW-1:0] r_level;     // node count at current level
    logic [NW-1:0] r_pair;      // parent index within level
    logic [3:0]  r_step;
    logic [511:0] r_msg;        // left and right digests
    logic [255:0] r_par;
    logic [2:0]  r_out_cnt;
    logic [1:0]  r_err;
    logic [255:0] r_root;

    logic [63:0] r_mem [WORDS];
    logic [63:0] r_rdata;
    logic        mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [63:0] mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_rdata <= r_mem[mem_ra];
    end

    mrk_pkg::t_cmp_req cmp_req;
    mrk_pkg::t_cmp_rsp cmp_rsp;
    mrk_compress u_cmp (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(cmp_req), .o_rsp(cmp_rsp));

    logic in_fire;
    assign o_in_ready = (r_state == S_LOAD);
    assign in_fire    = i_in_valid && o_in_ready;

    // Read address: steps 0..3 left node, 4..7 right node.
    logic [NW:0] l_node, r_node, rd_node;
    always_comb begin
        l_node  = {r_pair, 1'b0};
        r_node  = ((l_node + 1'b1) < {1'b0, r_level}) ? l_node + 1'b1 : l_node;
        rd_node = r_step[2] ? r_node : l_node;
        mem_ra  = AW'({rd_node, r_step[1:0]});
        if (r_state == S_ROOT) mem_ra = AW'(r_step[1:0]);
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = AW'(r_word_count);
        mem_wd = i_in_data.leaf_word;
        if (in_fire && i_in_data.word_valid && r_word_count < CW'(WORDS)) mem_we = 1'b1;
        if (r_state == S_WRITE) begin
            mem_we = 1'b1;
            mem_wa = AW'({r_pair, r_step[1:0]});
            mem_wd = r_par[255 - 64*r_step[1:0] -: 64];
        end
    end

    logic [511:0] blk1, blk2;
    always_comb begin
        blk1 = {mrk_pkg::DOMAIN_TEXT, 8'h00, r_msg[511:248]};
        blk2 = {r_msg[247:0], 8'h80, 240'h0, 16'h02f8};
        cmp_req.start  = 1'b0;
        cmp_req.second = 1'b0;
        cmp_req.block  = blk1;
        if (r_state == S_READ && r_step == 4'd9) cmp_req.start = 1'b1;
        if (r_state == S_CMP1 && cmp_rsp.done) begin
            cmp_req.start  = 1'b1;
            cmp_req.second = 1'b1;
            cmp_req.block  = blk2;
        end
    end

    logic [CW-1:0] wc_eff;
    logic          ov_eff;
    always_comb begin
        wc_eff = r_word_count;
        ov_eff = r_overflow;
        if (i_in_data.word_valid) begin
            if (r_word_count < CW'(WORDS)) wc_eff = r_word_count + 1'b1;
            else ov_eff = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_word_count <= '0;
            r_overflow   <= 1'b0;
            r_step       <= '0;
            r_out_cnt    <= '0;
        end else begin
            case (r_state)
                S_LOAD: begin
                    if (in_fire) begin
                        r_word_count <= wc_eff;
                        r_overflow   <= ov_eff;
                        if (i_in_data.close_table) begin
                            r_word_count <= '0;
                            r_overflow   <= 1'b0;
                            r_pair <= '0;
                            r_step <= '0;
                            r_level <= NW'(wc_eff >> 2);
                            if (wc_eff == '0) begin
                                r_err <= mrk_pkg::ERR_EMPTY;  r_state <= S_ERR;
                            end else if (ov_eff) begin
                                r_err <= mrk_pkg::ERR_TOOMANY; r_state <= S_ERR;
                            end else if (wc_eff[1:0] != 2'd0) begin
                                r_err <= mrk_pkg::ERR_PARTIAL; r_state <= S_ERR;
                            end else if ((wc_eff >> 2) == CW'(1)) begin
                                r_state <= S_ROOT;
                            end else begin
                                r_state <= S_READ;
                            end
                        end
                    end
                end
                S_READ: begin
                    // Data for the read issued at step s arrives at s+1.
                    if (r_step != 4'd0 && r_step <= 4'd8)
                        r_msg <= {r_msg[447:0], r_rdata};
                    r_step <= r_step + 4'd1;
                    if (r_step == 4'd9) begin
                        r_step <= '0;
                        r_state <= S_CMP1;
                    end
                end
                S_CMP1: if (cmp_rsp.done) r_state <= S_CMP2;
                S_CMP2: if (cmp_rsp.done) begin
                    r_par <= cmp_rsp.digest;
                    r_step <= '0;
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    r_step <= r_step + 4'd1;
                    if (r_step == 4'd3) begin
                        r_step <= '0;
                        if ({r_pair, 1'b0} + 2'd2 >= {1'b0, r_level}) begin
                            r_level <= r_pair + 1'b1;
                            r_pair  <= '0;
                            r_state <= (r_pair == '0) ? S_ROOT : S_READ;
                        end else begin
                            r_pair  <= r_pair + 1'b1;
                            r_state <= S_READ;
                        end
                    end
                end
                S_ROOT: begin
                    if (r_step != 4'd0) r_root <= {r_root[191:0], r_rdata};
                    r_step <= r_step + 4'd1;
                    if (r_step == 4'd4) begin
                        r_step <= '0;
                        r_out_cnt <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: if (i_out_ready) begin
                    r_out_cnt <= r_out_cnt + 3'd1;
                    if (r_out_cnt == 3'd3) r_state <= S_LOAD;
                end
                S_ERR: if (i_out_ready) r_state <= S_LOAD;
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_out_valid = (r_state == S_OUT) || (r_state == S_ERR);
    always_comb begin
        o_out_data.root_word  = 64'h0;
        o_out_data.error_code = mrk_pkg::ERR_OK;
        o_out_data.last_word  = 1'b1;
        if (r_state == S_OUT) begin
            o_out_data.root_word = r_root[255 - 64*r_out_cnt[1:0] -: 64];
            o_out_data.last_word = (r_out_cnt == 3'd3);
        end else begin
            o_out_data.error_code = r_err;
        end
    end

`ifndef SYNTHESIS
    a_err_code_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ERR) |-> (o_out_data.error_code != mrk_pkg::ERR_OK))
        else $error("error item with ok code");
    a_count_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD) |-> (r_word_count == '0 && !r_overflow))
        else $error("count not cleared after close");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_word_count <= CW'(WORDS))
        else $error("word count beyond table");
    a_pair_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> ({r_pair, 1'b0} < {1'b0, r_level}))
        else $error("pair beyond level");
`endif
endmodule

@@ rtl/mrk_compress.sv @@
// SHA-256 compression core, one round per cycle over 64 rounds.
// Depends on mrk_pkg for the round constants and handshake structs.
`timescale 1ns / 1ps
module mrk_compress (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mrk_pkg::t_cmp_req i_req,
    output mrk_pkg::t_cmp_rsp o_rsp
);
    logic         r_busy;
    logic [5:0]   r_round;
    logic [255:0] r_base;
    logic [255:0] r_work;
    logic [511:0] r_sched;
    logic         r_done;

    logic [31:0] a, b, c, d, e, f, g, h, w, t1, t2, s0, s1, x2, x15, wn;

    always_comb begin
        {a, b, c, d, e, f, g, h} = r_work;
        w   = r_sched[511:480];
        t1  = h + (mrk_pkg::rotr(e, 6) ^ mrk_pkg::rotr(e, 11) ^ mrk_pkg::rotr(e, 25))
              + ((e & f) ^ (~e & g)) + mrk_pkg::round_k(r_round) + w;
        t2  = (mrk_pkg::rotr(a, 2) ^ mrk_pkg::rotr(a, 13) ^ mrk_pkg::rotr(a, 22))
              + ((a & b) ^ (a & c) ^ (b & c));
        // Window holds W[t..t+15]; next entry W[t+16].
        x2  = r_sched[63:32];
        x15 = r_sched[479:448];
        s1  = mrk_pkg::rotr(x2, 17) ^ mrk_pkg::rotr(x2, 19) ^ (x2 >> 10);
        s0  = mrk_pkg::rotr(x15, 7) ^ mrk_pkg::rotr(x15, 18) ^ (x15 >> 3);
        wn  = s1 + r_sched[223:192] + s0 + w;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_round <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_round <= '0;
                r_base  <= i_req.second ? o_rsp.digest : mrk_pkg::INITIAL_H;
                r_work  <= i_req.second ? o_rsp.digest : mrk_pkg::INITIAL_H;
                r_sched <= i_req.block;
            end else if (r_busy) begin
                r_work  <= {t1 + t2, a, b, c, d + t1, e, f, g};
                r_sched <= {r_sched[479:0], wn};
                r_round <= r_round + 6'd1;
                if (r_round == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Digest is the final sum, held in r_digest after completion.
    logic [255:0] r_digest;
    always_ff @(posedge i_clk) begin
        if (r_busy && r_round == 6'd63) begin
            r_digest <= {r_base[255:224] + t1 + t2, r_base[223:192] + a,
                         r_base[191:160] + b, r_base[159:128] + c,
                         r_base[127:96] + d + t1, r_base[95:64] + e,
                         r_base[63:32] + f, r_base[31:0] + g};
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.digest = r_digest;

`ifndef SYNTHESIS
    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_round == 6'd63 && !i_req.start) |=> r_done)
        else $error("done missing after last round");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_req.start)
        else $error("start while busy");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("done while busy");
`endif
endmodule
